// File: rtl/core/wrm_pkg.sv
// Shared types, defaults and ordering helper for the weighted running median.
package wrm_pkg;

  localparam int unsigned HeapCapacityDef = 1024;
  localparam int unsigned WeightBitsDef   = 16;

  typedef struct packed {
    logic signed [31:0] key;
    logic [15:0]        weight;
  } in_t;

  typedef struct packed {
    logic signed [32:0] median_twice;
    logic               empty_res;
    logic               full_dropped;
  } out_t;

  typedef struct packed {
    logic ready;
    logic done;
  } seq_stat_t;

  // key first (signed), then weight (unsigned)
  function automatic logic pair_gt(logic signed [31:0] ka, logic [31:0] wa,
                                   logic signed [31:0] kb, logic [31:0] wb);
    return (ka > kb) || ((ka == kb) && (wa > wb));
  endfunction

endpackage

// File: rtl/core/wrm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wrm_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/wrm_seq.sv
// Heap sequencer: insert, sift up/down through the heap RAMs, rebalance, median.
module wrm_seq #(
  parameter int unsigned HEAP_CAPACITY = wrm_pkg::HeapCapacityDef,
  parameter int unsigned WEIGHT_BITS   = wrm_pkg::WeightBitsDef
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  wrm_pkg::in_t                     item,
  input  logic                             out_free,
  output wrm_pkg::seq_stat_t               stat,
  output wrm_pkg::out_t                    res,
  output logic [1:0]                       mem_we,
  output logic [$clog2(HEAP_CAPACITY)-1:0] mem_waddr,
  output logic [WEIGHT_BITS+31:0]          mem_wdata,
  output logic [$clog2(HEAP_CAPACITY)-1:0] mem_raddr,
  input  logic [WEIGHT_BITS+31:0]          rdata_lo,
  input  logic [WEIGHT_BITS+31:0]          rdata_up
);

  localparam int unsigned AW = $clog2(HEAP_CAPACITY);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned LW = AW + 2;
  localparam int unsigned WB = WEIGHT_BITS;
  localparam int unsigned EW = WB + 32;
  localparam int unsigned SW = WB + AW + 1;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_UP    = 11'b00000000010,
    S_UPW   = 11'b00000000100,
    S_REBAL = 11'b00000001000,
    S_POPL  = 11'b00000010000,
    S_DN    = 11'b00000100000,
    S_DNL   = 11'b00001000000,
    S_DNR   = 11'b00010000000,
    S_DNC   = 11'b00100000000,
    S_PUSHM = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

  state_t          state_r, state_nxt;
  logic            h_r, h_nxt;
  logic [AW-1:0]   i_r, i_nxt;
  logic [EW-1:0]   cur_r, cur_nxt;
  logic [EW-1:0]   last_r, last_nxt;
  logic [EW-1:0]   mv_r, mv_nxt;
  logic [EW-1:0]   lval_r, lval_nxt;
  logic [EW-1:0]   rval_r, rval_nxt;
  logic            rvalid_r, rvalid_nxt;
  logic            drop_r, drop_nxt;
  logic [CW-1:0]   cnt_r [2];
  logic [CW-1:0]   cnt_nxt [2];
  logic [SW-1:0]   sum_r [2];
  logic [SW-1:0]   sum_nxt [2];
  logic [EW-1:0]   root_r [2];
  logic [EW-1:0]   root_nxt [2];

  logic [EW-1:0]   rd;
  logic [31:0]     w32;
  logic [EW-1:0]   in_e;
  logic [AW-1:0]   par;
  logic [LW-1:0]   lidx, ridx, cnt_h;
  logic            take_l, take_r;
  logic [EW-1:0]   best_v;
  logic [LW-1:0]   best_i;
  logic [CW-1:0]   cnt_dec;
  logic            mv_up, mv_lo;
  logic signed [32:0] k0, k1;
  logic            sums_zero;

  function automatic logic signed [31:0] ekey(logic [EW-1:0] e);
    return e[EW-1 -: 32];
  endfunction

  function automatic logic [31:0] ewt(logic [EW-1:0] e);
    return 32'(e[WB-1:0]);
  endfunction

  // true when a sits above b in heap h (0: max-heap, 1: min-heap)
  function automatic logic ranks(logic h, logic [EW-1:0] a, logic [EW-1:0] b);
    if (h) return wrm_pkg::pair_gt(ekey(b), ewt(b), ekey(a), ewt(a));
    return wrm_pkg::pair_gt(ekey(a), ewt(a), ekey(b), ewt(b));
  endfunction

  assign rd     = h_r ? rdata_up : rdata_lo;
  assign w32    = 32'(item.weight);
  assign in_e   = {item.key, w32[WB-1:0]};
  assign par    = AW'((i_r - AW'(1)) >> 1);
  assign lidx   = LW'((LW'(i_r) << 1) + LW'(1));
  assign ridx   = LW'((LW'(i_r) << 1) + LW'(2));
  assign cnt_h  = LW'(cnt_r[h_r]);
  assign take_l = ranks(h_r, lval_r, last_r);
  assign best_v = take_l ? lval_r : last_r;
  assign take_r = rvalid_r && ranks(h_r, rval_r, best_v);
  assign best_i = take_r ? ridx : (take_l ? lidx : LW'(i_r));
  assign mv_up  = (cnt_r[1] != '0) &&
                  ({1'b0, sum_r[1]} > ({1'b0, sum_r[0]} + (SW+1)'(root_r[1][WB-1:0])));
  assign mv_lo  = (cnt_r[0] != '0) &&
                  ({1'b0, sum_r[0]} > ({1'b0, sum_r[1]} + (SW+1)'(root_r[0][WB-1:0])));
  assign k0     = 33'(ekey(root_r[0]));
  assign k1     = 33'(ekey(root_r[1]));
  assign sums_zero = (sum_r[0] == '0) && (sum_r[1] == '0);

  always_comb begin
    state_nxt  = state_r;
    h_nxt      = h_r;
    i_nxt      = i_r;
    cur_nxt    = cur_r;
    last_nxt   = last_r;
    mv_nxt     = mv_r;
    lval_nxt   = lval_r;
    rval_nxt   = rval_r;
    rvalid_nxt = rvalid_r;
    drop_nxt   = drop_r;
    cnt_nxt    = cnt_r;
    sum_nxt    = sum_r;
    root_nxt   = root_r;
    mem_we     = 2'b00;
    mem_waddr  = i_r;
    mem_wdata  = cur_r;
    mem_raddr  = par;
    cnt_dec    = '0;
    stat.ready = 1'b0;
    stat.done  = 1'b0;
    res.median_twice = '0;
    res.empty_res    = sums_zero;
    res.full_dropped = drop_r;
    case (state_r)
      S_IDLE: begin
        stat.ready = 1'b1;
        if (start) begin
          drop_nxt = 1'b0;
          cur_nxt  = in_e;
          if ((cnt_r[1] != '0) && (item.key <= ekey(root_r[1]))) h_nxt = 1'b0;
          else h_nxt = 1'b1;
          if (cnt_r[h_nxt] >= CW'(HEAP_CAPACITY)) begin
            drop_nxt  = 1'b1;
            state_nxt = S_REBAL;
          end else begin
            i_nxt          = AW'(cnt_r[h_nxt]);
            cnt_nxt[h_nxt] = cnt_r[h_nxt] + CW'(1);
            sum_nxt[h_nxt] = sum_r[h_nxt] + SW'(w32[WB-1:0]);
            state_nxt      = S_UP;
          end
        end
      end
      S_UP: begin
        if (i_r == '0) begin
          mem_we[h_r]  = 1'b1;
          root_nxt[h_r] = cur_r;
          state_nxt    = S_REBAL;
        end else begin
          state_nxt = S_UPW;
        end
      end
      S_UPW: begin
        mem_we[h_r] = 1'b1;
        if (ranks(h_r, cur_r, rd)) begin
          mem_wdata = rd;
          i_nxt     = par;
          state_nxt = S_UP;
        end else begin
          state_nxt = S_REBAL;
        end
      end
      S_REBAL: begin
        if (mv_up || mv_lo) begin
          h_nxt = mv_up ? 1'b1 : 1'b0;
          if (cnt_r[~h_nxt] >= CW'(HEAP_CAPACITY)) begin
            state_nxt = S_OUT;
          end else begin
            cnt_dec        = cnt_r[h_nxt] - CW'(1);
            mv_nxt         = root_r[h_nxt];
            cnt_nxt[h_nxt] = cnt_dec;
            sum_nxt[h_nxt] = sum_r[h_nxt] - SW'(root_r[h_nxt][WB-1:0]);
            mem_raddr      = cnt_dec[AW-1:0];
            i_nxt          = '0;
            state_nxt      = (cnt_dec == '0) ? S_PUSHM : S_POPL;
          end
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_POPL: begin
        last_nxt  = rd;
        state_nxt = S_DN;
      end
      S_DN: begin
        if (lidx < cnt_h) begin
          mem_raddr = lidx[AW-1:0];
          state_nxt = S_DNL;
        end else begin
          mem_we[h_r] = 1'b1;
          mem_wdata   = last_r;
          if (i_r == '0) root_nxt[h_r] = last_r;
          state_nxt = S_PUSHM;
        end
      end
      S_DNL: begin
        lval_nxt   = rd;
        rvalid_nxt = 1'b0;
        if (ridx < cnt_h) begin
          mem_raddr = ridx[AW-1:0];
          state_nxt = S_DNR;
        end else begin
          state_nxt = S_DNC;
        end
      end
      S_DNR: begin
        rval_nxt   = rd;
        rvalid_nxt = 1'b1;
        state_nxt  = S_DNC;
      end
      S_DNC: begin
        mem_we[h_r] = 1'b1;
        if (!take_l && !take_r) begin
          mem_wdata = last_r;
          if (i_r == '0) root_nxt[h_r] = last_r;
          state_nxt = S_PUSHM;
        end else begin
          mem_wdata = take_r ? rval_r : lval_r;
          if (i_r == '0) root_nxt[h_r] = mem_wdata;
          i_nxt     = best_i[AW-1:0];
          state_nxt = S_DN;
        end
      end
      S_PUSHM: begin
        h_nxt          = ~h_r;
        cur_nxt        = mv_r;
        i_nxt          = AW'(cnt_r[~h_r]);
        cnt_nxt[~h_r]  = cnt_r[~h_r] + CW'(1);
        sum_nxt[~h_r]  = sum_r[~h_r] + SW'(mv_r[WB-1:0]);
        state_nxt      = S_UP;
      end
      S_OUT: begin
        if (!sums_zero) begin
          if (sum_r[0] == '0)            res.median_twice = k1 <<< 1;
          else if (sum_r[1] == '0)       res.median_twice = k0 <<< 1;
          else if (sum_r[0] == sum_r[1]) res.median_twice = k0 + k1;
          else if (sum_r[0] > sum_r[1])  res.median_twice = k0 <<< 1;
          else                           res.median_twice = k1 <<< 1;
        end
        if (out_free) begin
          stat.done = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '{default: '0};
      sum_r   <= '{default: '0};
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
    end
    h_r      <= h_nxt;
    i_r      <= i_nxt;
    cur_r    <= cur_nxt;
    last_r   <= last_nxt;
    mv_r     <= mv_nxt;
    lval_r   <= lval_nxt;
    rval_r   <= rval_nxt;
    rvalid_r <= rvalid_nxt;
    drop_r   <= drop_nxt;
    root_r   <= root_nxt;
  end

endmodule

// File: rtl/core/weighted_running_median.sv
// Top level: heap RAMs, sequencer and result register.
// Each item is one (key, weight) insert; one result item follows per input item.
// An accepted item is inserted and sifted up its heap; a dropped insert skips the
// sift-up. Rebalancing then moves roots between the heaps: each move pops the root,
// sifts the last entry down (up to two child reads per level on the single RAM read
// port) and sifts the moved root up in the other heap; a move out of a single-entry
// heap skips the sift-down. The block takes one item at a time; in_stall is high
// from acceptance until the result is loaded into the output register, which may
// still be waiting when the next item is accepted.
// No clearing pass follows reset: only entries below the counts are ever read.
module weighted_running_median #(
  parameter int unsigned HEAP_CAPACITY = wrm_pkg::HeapCapacityDef,
  parameter int unsigned WEIGHT_BITS   = wrm_pkg::WeightBitsDef
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  wrm_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output wrm_pkg::out_t out_data
);

  localparam int unsigned AW = $clog2(HEAP_CAPACITY);
  localparam int unsigned EW = WEIGHT_BITS + 32;

  wrm_pkg::seq_stat_t stat;
  wrm_pkg::out_t      res;
  wrm_pkg::out_t      out_data_r;
  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         mem_we;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  logic [EW-1:0]      mem_wdata, rdata_lo, rdata_up;
  logic               out_free;

  assign in_stall = !stat.ready;
  assign out_free = !out_valid_r || !out_stall;

  wrm_seq #(
    .HEAP_CAPACITY (HEAP_CAPACITY),
    .WEIGHT_BITS   (WEIGHT_BITS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_valid && stat.ready),
    .item      (in_data),
    .out_free  (out_free),
    .stat      (stat),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .rdata_lo  (rdata_lo),
    .rdata_up  (rdata_up)
  );

  wrm_ram #(.WIDTH(EW), .DEPTH(HEAP_CAPACITY)) u_lower (
    .clk   (clk),
    .we    (mem_we[0]),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rdata_lo)
  );

  wrm_ram #(.WIDTH(EW), .DEPTH(HEAP_CAPACITY)) u_upper (
    .clk   (clk),
    .we    (mem_we[1]),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rdata_up)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (stat.done) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (stat.done) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/core/wrm_checker.sv
// Port-level checks for the weighted running median, bound to the top level.
module wrm_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input wrm_pkg::out_t out_data
);

  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again straight after an accept");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.empty_res |-> out_data.median_twice == '0)
    else $error("empty result with non-zero median");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result item changed");

endmodule

bind weighted_running_median wrm_checker u_wrm_checker (.*);

// File: tb/sv/tb_weighted_running_median.sv
// Testbench for the weighted running median: heap-based predictor and scoreboard.
module tb_weighted_running_median;

  localparam int unsigned Cap = wrm_pkg::HeapCapacityDef;
  localparam int NumItems = 1900;
  localparam longint CycleLimit = 3000000;

  typedef struct packed {
    logic signed [31:0] key;
    logic [31:0]        w;
  } ent_t;

  class median_scoreboard;
    ent_t lo_h[Cap];
    ent_t up_h[Cap];
    int unsigned lo_n, up_n;
    longint unsigned lo_sum, up_sum;
    wrm_pkg::out_t pending[$];
    int errors;

    function new();
      lo_n = 0; up_n = 0; lo_sum = 0; up_sum = 0; errors = 0;
    endfunction

    // is_max: lower heap ranks greater pairs higher
    function bit above(bit is_max, ent_t a, ent_t b);
      return is_max ? wrm_pkg::pair_gt(a.key, a.w, b.key, b.w)
                    : wrm_pkg::pair_gt(b.key, b.w, a.key, a.w);
    endfunction

    function bit push(bit is_max, ent_t v);
      int unsigned i, p;
      ent_t t;
      if (is_max) begin
        if (lo_n >= Cap) return 0;
        i = lo_n; lo_h[i] = v; lo_n++; lo_sum += v.w;
        while (i > 0) begin
          p = (i - 1) / 2;
          if (!above(1, lo_h[i], lo_h[p])) break;
          t = lo_h[i]; lo_h[i] = lo_h[p]; lo_h[p] = t; i = p;
        end
      end else begin
        if (up_n >= Cap) return 0;
        i = up_n; up_h[i] = v; up_n++; up_sum += v.w;
        while (i > 0) begin
          p = (i - 1) / 2;
          if (!above(0, up_h[i], up_h[p])) break;
          t = up_h[i]; up_h[i] = up_h[p]; up_h[p] = t; i = p;
        end
      end
      return 1;
    endfunction

    function ent_t pop(bit is_max);
      ent_t top, t;
      ent_t h[Cap];
      int unsigned i, l, r, best, n;
      if (is_max) begin h = lo_h; n = lo_n; end else begin h = up_h; n = up_n; end
      top = h[0];
      n--;
      h[0] = h[n];
      i = 0;
      forever begin
        l = 2 * i + 1; r = 2 * i + 2; best = i;
        if (l < n && above(is_max, h[l], h[best])) best = l;
        if (r < n && above(is_max, h[r], h[best])) best = r;
        if (best == i) break;
        t = h[i]; h[i] = h[best]; h[best] = t; i = best;
      end
      if (is_max) begin lo_h = h; lo_n = n; lo_sum -= top.w; end
      else begin up_h = h; up_n = n; up_sum -= top.w; end
      return top;
    endfunction

    function void note_input(wrm_pkg::in_t d);
      ent_t v;
      bit dropped, ok;
      wrm_pkg::out_t r;
      longint med;
      v.key = d.key;
      v.w = {16'd0, d.weight};
      if (up_n > 0 && v.key <= up_h[0].key) dropped = !push(1, v);
      else dropped = !push(0, v);
      forever begin
        if (up_n > 0 && up_sum > lo_sum + up_h[0].w) begin
          if (lo_n >= Cap) break;
          ok = push(1, pop(0));
        end else if (lo_n > 0 && lo_sum > up_sum + lo_h[0].w) begin
          if (up_n >= Cap) break;
          ok = push(0, pop(1));
        end else break;
      end
      med = 0;
      r.empty_res = (lo_sum == 0 && up_sum == 0);
      if (!r.empty_res) begin
        if (lo_sum == 0) med = 2 * longint'(up_h[0].key);
        else if (up_sum == 0) med = 2 * longint'(lo_h[0].key);
        else if (lo_sum == up_sum) med = longint'(lo_h[0].key) + longint'(up_h[0].key);
        else if (lo_sum > up_sum) med = 2 * longint'(lo_h[0].key);
        else med = 2 * longint'(up_h[0].key);
      end
      r.median_twice = med[32:0];
      r.full_dropped = dropped;
      pending.insert(pending.size(), r);
    endfunction

    function void check_result(wrm_pkg::out_t got);
      wrm_pkg::out_t e;
      if (pending.size() == 0) begin
        $error("result with nothing expected: %h", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.median_twice !== e.median_twice) begin
        $error("median_twice expected %0d got %0d", e.median_twice, got.median_twice);
        errors++;
      end
      if (got.empty_res !== e.empty_res) begin
        $error("empty_res expected %0d got %0d", e.empty_res, got.empty_res);
        errors++;
      end
      if (got.full_dropped !== e.full_dropped) begin
        $error("full_dropped expected %0d got %0d", e.full_dropped, got.full_dropped);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n, in_valid, in_stall, out_valid, out_stall;
  wrm_pkg::in_t in_data;
  wrm_pkg::out_t out_data;

  median_scoreboard sb;
  bit quiet_tail;
  bit hold_rx;
  longint cycles;

  weighted_running_median u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // scoreboard tap on both handshakes
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_input(in_data);
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // receiver: random stall bursts, plus one long hold-off
  initial begin
    int n;
    out_stall <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_rx) begin
        out_stall <= 1'b1;
        repeat (600) @(posedge clk);
        hold_rx = 0;
      end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 12);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end else begin
        n = $urandom_range(1, 20);
        out_stall <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  // valid stays high after an accept so that items can follow back to back
  task automatic send_item(logic signed [31:0] k, logic [15:0] w);
    int gap;
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data.key <= k;
    in_data.weight <= w;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_weight();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom());
      default: return 16'($urandom_range(1, 40));
    endcase
  endfunction

  function automatic logic signed [31:0] rand_key();
    case ($urandom_range(0, 5))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return 32'($urandom());
      default: return 32'($signed($urandom_range(0, 200)) - 100);
    endcase
  endfunction

  initial begin
    int i;
    sb = new();
    quiet_tail = 0;
    hold_rx = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero weights: stored but result stays empty
    send_item(32'sd5, 16'd0);
    send_item(-32'sd3, 16'd0);
    // one side of zero weight, then extremes
    send_item(32'sh7FFF_FFFF, 16'hFFFF);
    send_item(32'sh8000_0000, 16'hFFFF);
    send_item(32'sh8000_0000, 16'd1);
    send_item(32'sh7FFF_FFFF, 16'd1);
    send_item(32'sd0, 16'd2);
    send_item(32'sd0, 16'd2);
    send_item(-32'sd1, 16'h8000);
    send_item(32'sd1, 16'h7FFF);
    send_item(32'sh5555_5555, 16'h5555);
    send_item(32'shAAAA_AAAA, 16'hAAAA);
    drain();

    // long receiver hold-off while offering items
    hold_rx = 1;
    for (i = 0; i < 20; i++) send_item(rand_key(), rand_weight());
    drain();

    // fill the upper heap with rising keys of weight zero until full drops
    for (i = 0; i < 1100; i++) send_item(32'sh4000_0000 + i, 16'd0);
    // random mix, also exercising rebalance against full heaps
    for (i = 0; i < 700; i++) begin
      if (i == 600) begin
        drain();
        quiet_tail = 1;
      end
      send_item(rand_key(), rand_weight());
    end
    drain();
    repeat (4000) begin
      @(posedge clk);
      if (sb.pending.size() != 0) break;
    end
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/wrm_pkg.sv
rtl/core/wrm_ram.sv
rtl/core/wrm_seq.sv
rtl/core/weighted_running_median.sv
rtl/core/wrm_checker.sv
tb/sv/tb_weighted_running_median.sv
